FILE: rtl/mlfl_pkg.sv
// Shared types, constants and helpers of the marker/length frame locator.
package mlfl_pkg;

  localparam int BUFFER_DEPTH_DEF  = 1024;
  localparam int MAX_TAG_BYTES_DEF = 4;

  localparam int BYTE_W     = 8;
  localparam int TAG_W      = 32;
  localparam int TAG_LEN_W  = 3;
  localparam int START_W    = 10;
  localparam int PLEN_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int REG_IDX_W  = 8;
  localparam int REG_DATA_W = 32;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BEGIN_TAG     = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEGIN_TAG_LEN = 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_TAG       = 8'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_TAG_LEN   = 8'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  payload_start;
    logic [PLEN_W-1:0]   payload_length;
  } out_beat_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [REG_DATA_W-1:0] wr_data;
  } cfg_beat_t;

  // control from the sequencer to the frame buffer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } buf_ctl_t;

  // byte k of a marker; bytes past bit 31 read as zero
  function automatic logic [BYTE_W-1:0] tag_byte(input logic [TAG_W-1:0] tag,
                                                 input int unsigned k);
    logic [2*TAG_W-1:0] ext;
    ext = {{TAG_W{1'b0}}, tag};
    return ext[BYTE_W*(k & 7) +: BYTE_W];
  endfunction

endpackage

FILE: rtl/mlfl_if.sv
// Valid/ready channel interfaces: byte input, result output, register writes.
interface mlfl_in_if;
  logic               valid;
  logic               ready;
  mlfl_pkg::in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface mlfl_out_if;
  logic                valid;
  logic                ready;
  mlfl_pkg::out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface mlfl_cfg_if;
  logic                valid;
  logic                ready;
  mlfl_pkg::cfg_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

FILE: rtl/mlfl_frame_buf.sv
// Frame byte buffer: write-at-fill-count memory, one registered read port.
module mlfl_frame_buf #(
  parameter int BUFFER_DEPTH = mlfl_pkg::BUFFER_DEPTH_DEF,
  localparam int ADDR_W = $clog2(BUFFER_DEPTH),
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlfl_pkg::buf_ctl_t          ctl_i,
  input  logic [mlfl_pkg::BYTE_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [mlfl_pkg::BYTE_W-1:0] rd_data_o,
  output logic [CNT_W-1:0]            count_o,
  output logic                        overflow_o
);

  logic [mlfl_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [mlfl_pkg::BYTE_W-1:0] rd_data_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        full;

  assign full = (count_q == CNT_W'(BUFFER_DEPTH));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctl_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (ctl_i.wr_en) begin
      if (full) begin
        ovf_d = 1'b1;            // byte dropped
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && !full) begin
      mem[ADDR_W'(count_q)] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign count_o    = count_q;
  assign overflow_o = ovf_q;

endmodule

FILE: rtl/marker_length_frame_locator.sv
// Marker/length frame locator top level: register file, search sequencer, result register.
//
//  channel  dir  beat payload                               beat accepted
//  -------  ---  -------------------------------------      ---------------------
//  in_i     in   data_byte[7:0], last_byte                  valid & ready
//  out_o    out  status[1:0], payload_start[9:0],           valid & ready
//                payload_length[7:0]
//  cfg_i    in   reg_idx[7:0], wr_data[31:0]                valid & ready (always ready)
//
//  Bytes load at one per cycle into the frame buffer. After the last byte, a
//  setup state, then a scan that reads the buffer through its single read
//  port, plus an end-marker check for every begin-marker hit whose end
//  position fits in the buffer; overflow and zero marker lengths answer right
//  after setup. in_i stalls from the last byte until the result is in the
//  output register; the output register lets the next frame load while a
//  result waits. Reset is asynchronous, active low; no clearing pass, the
//  buffer is only read below its fill count.
module marker_length_frame_locator #(
  parameter int BUFFER_DEPTH  = mlfl_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_TAG_BYTES = mlfl_pkg::MAX_TAG_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlfl_in_if.sink    in_i,
  mlfl_out_if.source out_o,
  mlfl_cfg_if.sink   cfg_i
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int TL_W   = $clog2(MAX_TAG_BYTES + 1);
  // end position can run past the buffer by a length byte and a marker
  localparam int SPAN_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int BW     = mlfl_pkg::BYTE_W;

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  // ---------------------------------------------------------------- registers
  logic [mlfl_pkg::TAG_W-1:0]     begin_tag_q, end_tag_q;
  logic [mlfl_pkg::TAG_LEN_W-1:0] begin_len_q, end_len_q;

  logic [2:0]                     state_q, state_d;
  logic [CNT_W-1:0]               scan_q, scan_d;      // next scan read address
  logic [CNT_W-1:0]               da_q, da_d;          // address of data in flight
  logic                           dv_q, dv_d;          // read data valid this cycle
  logic [TL_W-1:0]                off_iss_q, off_iss_d; // end marker byte to read next
  logic [TL_W-1:0]                doff_q, doff_d;      // end marker byte in flight
  logic [CNT_W-1:0]               end_base_q, end_base_d;
  logic [CNT_W-1:0]               st_q, st_d;          // payload start of candidate
  logic [BW-1:0]                  plen_q, plen_d;
  logic [mlfl_pkg::STATUS_W-1:0]  res_q, res_d;
  logic [BW-1:0]                  win_q [MAX_TAG_BYTES];
  logic [BW-1:0]                  win_d [MAX_TAG_BYTES];

  logic                           out_valid_q, out_valid_d;
  mlfl_pkg::out_beat_t            out_beat_q, out_beat_d;

  // ------------------------------------------------------------ frame buffer
  mlfl_pkg::buf_ctl_t             buf_ctl;
  logic [ADDR_W-1:0]              rd_addr;
  logic [BW-1:0]                  rd_data;
  logic [CNT_W-1:0]               byte_cnt;
  logic                           overflowed;

  mlfl_frame_buf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (buf_ctl),
    .wr_data_i  (in_i.beat.data_byte),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .count_o    (byte_cnt),
    .overflow_o (overflowed)
  );

  // ---------------------------------------------------------- configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_tag_q <= '0;
      begin_len_q <= mlfl_pkg::TAG_LEN_W'(1);
      end_tag_q   <= '0;
      end_len_q   <= mlfl_pkg::TAG_LEN_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.beat.reg_idx)
        mlfl_pkg::REG_BEGIN_TAG:     begin_tag_q <= cfg_i.beat.wr_data;
        mlfl_pkg::REG_BEGIN_TAG_LEN: begin_len_q <= cfg_i.beat.wr_data[2:0];
        mlfl_pkg::REG_END_TAG:       end_tag_q   <= cfg_i.beat.wr_data;
        mlfl_pkg::REG_END_TAG_LEN:   end_len_q   <= cfg_i.beat.wr_data[2:0];
        default: ;                   // unmapped index ignored
      endcase
    end
  end

  // marker lengths saturate at MAX_TAG_BYTES
  logic [TL_W-1:0] bl, el;
  assign bl = (int'(begin_len_q) > MAX_TAG_BYTES) ? TL_W'(MAX_TAG_BYTES)
                                                  : TL_W'(begin_len_q);
  assign el = (int'(end_len_q) > MAX_TAG_BYTES) ? TL_W'(MAX_TAG_BYTES)
                                                : TL_W'(end_len_q);

  // ------------------------------------------------------- scan window logic
  // win_new[0] is the byte at da_q, win_new[i] the byte i places earlier.
  // With the length byte at da_q, the begin marker starts at da_q - bl.
  logic [BW-1:0]     win_new [MAX_TAG_BYTES+1];
  logic              begin_ok;
  logic [SPAN_W-1:0] end_pos;
  logic              end_fits;
  logic              begin_hit;

  always_comb begin
    win_new[0] = rd_data;
    for (int i = 1; i <= MAX_TAG_BYTES; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  always_comb begin
    logic [TL_W-1:0] idx;
    begin_ok = 1'b1;
    for (int k = 0; k < MAX_TAG_BYTES; k++) begin
      idx = TL_W'(int'(bl) - k);
      if ((k < int'(bl)) &&
          (win_new[idx] != mlfl_pkg::tag_byte(begin_tag_q, k))) begin
        begin_ok = 1'b0;
      end
    end
  end

  // the length byte fixes the only end position that can pair with this begin
  assign end_pos   = SPAN_W'(da_q) + SPAN_W'(1) + SPAN_W'(rd_data);
  assign end_fits  = (end_pos + SPAN_W'(el)) <= SPAN_W'(byte_cnt);
  assign begin_hit = begin_ok && (da_q >= CNT_W'(bl)) && end_fits;

  // ---------------------------------------------------------------- sequencer
  logic in_acc;
  logic out_free;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    da_d        = da_q;
    dv_d        = 1'b0;
    off_iss_d   = off_iss_q;
    doff_d      = doff_q;
    end_base_d  = end_base_q;
    st_d        = st_q;
    plen_d      = plen_q;
    res_d       = res_q;
    win_d       = win_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_beat_d  = out_beat_q;
    rd_addr     = ADDR_W'(scan_q);
    buf_ctl     = '{wr_en: in_acc, rd_en: 1'b0, clear: 1'b0};

    case (state_q)
      S_LOAD: begin
        if (in_acc && in_i.beat.last_byte) begin
          state_d = S_START;
        end
      end

      S_START: begin
        if (overflowed) begin
          res_d   = mlfl_pkg::ST_OVERFLOW;
          state_d = S_RES;
        end else if ((bl == '0) || (el == '0)) begin
          res_d   = mlfl_pkg::ST_NONE;
          state_d = S_RES;
        end else begin
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_q < byte_cnt) begin
          buf_ctl.rd_en = 1'b1;
          scan_d        = scan_q + 1'b1;
          da_d          = scan_q;
          dv_d          = 1'b1;
        end
        if (dv_q) begin
          for (int i = 0; i < MAX_TAG_BYTES; i++) begin
            win_d[i] = win_new[i];
          end
          if (begin_hit) begin
            // check the end marker; the read in flight is dropped and
            // the scan resumes right after the length byte
            dv_d       = 1'b0;
            scan_d     = da_q + 1'b1;
            st_d       = da_q + 1'b1;
            plen_d     = rd_data;
            end_base_d = CNT_W'(end_pos);
            off_iss_d  = '0;
            state_d    = S_END;
          end else if (da_q == byte_cnt - 1'b1) begin
            res_d   = mlfl_pkg::ST_NONE;
            state_d = S_RES;
          end
        end
      end

      S_END: begin
        rd_addr = ADDR_W'(end_base_q + CNT_W'(off_iss_q));
        if (off_iss_q < el) begin
          buf_ctl.rd_en = 1'b1;
          off_iss_d     = TL_W'(off_iss_q + 1'b1);
          doff_d        = off_iss_q;
          dv_d          = 1'b1;
        end
        if (dv_q) begin
          if (rd_data != mlfl_pkg::tag_byte(end_tag_q, int'(doff_q))) begin
            dv_d    = 1'b0;
            state_d = S_SCAN;
          end else if (doff_q == TL_W'(el - 1'b1)) begin
            res_d   = mlfl_pkg::ST_FOUND;
            state_d = S_RES;
          end
        end
      end

      S_RES: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_beat_d.status         = res_q;
          out_beat_d.payload_start  = '0;
          out_beat_d.payload_length = '0;
          if (res_q == mlfl_pkg::ST_FOUND) begin
            out_beat_d.payload_start  = mlfl_pkg::START_W'(st_q);
            out_beat_d.payload_length = plen_q;
          end
          buf_ctl.clear = 1'b1;
          state_d       = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    da_q       <= da_d;
    off_iss_q  <= off_iss_d;
    doff_q     <= doff_d;
    end_base_q <= end_base_d;
    st_q       <= st_d;
    plen_q     <= plen_d;
    res_q      <= res_d;
    win_q      <= win_d;
    out_beat_q <= out_beat_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.beat  = out_beat_q;

  // --------------------------------------------------------------- assertions
  // a new result only comes out of the result state
  a_result_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(state_q) == S_RES)
    else $error("result loaded outside result state");

  // an accepted frame ends where its length byte says
  a_found_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END && state_d == S_RES) |->
      end_base_q == st_q + CNT_W'(plen_q))
    else $error("end marker position disagrees with length byte");

  // the buffer is never empty at setup: it holds the last byte, or is full if it overflowed
  a_start_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |-> (byte_cnt != '0))
    else $error("search started on an empty buffer");

  // fill count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the marker/length frame locator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = mlfl_pkg::BUFFER_DEPTH_DEF;
  localparam int unsigned TAG_CAP      = mlfl_pkg::MAX_TAG_BYTES_DEF;
  // random traffic; the overflow frame adds about one buffer depth on top
  localparam int unsigned RANDOM_BYTES = 240;
  localparam int unsigned PHASES       = 8;
  // give the block room to settle
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned END_SETTLE   = 64;
  // longest legal quiet stretch is one full-buffer scan with many begin hits
  localparam int unsigned STALL_LIMIT  = 100000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Shadow of the locator: buffer, fill count, overflow flag, registers, and the
  // reports the block still owes us.
  class locator_scoreboard;
    logic [mlfl_pkg::BYTE_W-1:0]    frame_mem [DEPTH];
    int unsigned                    fill;
    bit                             overflowed;
    logic [mlfl_pkg::TAG_W-1:0]     begin_tag;
    logic [mlfl_pkg::TAG_W-1:0]     end_tag;
    logic [mlfl_pkg::TAG_LEN_W-1:0] begin_len;
    logic [mlfl_pkg::TAG_LEN_W-1:0] end_len;
    mlfl_pkg::out_beat_t            awaited_reports [$];
    int unsigned                    failures;

    function new();
      fill       = 0;
      overflowed = 0;
      begin_tag  = '0;
      end_tag    = '0;
      begin_len  = 1;
      end_len    = 1;
      failures   = 0;
    endfunction

    function int unsigned eff_len(input logic [mlfl_pkg::TAG_LEN_W-1:0] len);
      return (len > TAG_CAP) ? TAG_CAP : int'(len);
    endfunction

    function void write_reg(input logic [mlfl_pkg::REG_IDX_W-1:0] idx,
                            input logic [mlfl_pkg::REG_DATA_W-1:0] data);
      case (idx)
        mlfl_pkg::REG_BEGIN_TAG:     begin_tag = data;
        mlfl_pkg::REG_BEGIN_TAG_LEN: begin_len = data[mlfl_pkg::TAG_LEN_W-1:0];
        mlfl_pkg::REG_END_TAG:       end_tag   = data;
        mlfl_pkg::REG_END_TAG_LEN:   end_len   = data[mlfl_pkg::TAG_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // marker must sit wholly inside the filled part of the buffer
    function bit tag_hit(input int unsigned pos, input logic [mlfl_pkg::TAG_W-1:0] tag,
                         input int unsigned len);
      int unsigned k;
      if (len == 0 || pos + len > fill) return 0;
      for (k = 0; k < len; k++) begin
        if (frame_mem[pos+k] !== tag[8*k +: 8]) return 0;
      end
      return 1;
    endfunction

    // first begin hit, then first end hit at or after it with a matching length byte
    function mlfl_pkg::out_beat_t search_frame();
      mlfl_pkg::out_beat_t rpt;
      int unsigned         bl;
      int unsigned         el;
      int unsigned         b;
      int unsigned         e;
      int unsigned         span;
      bit                  found;
      rpt.status         = mlfl_pkg::ST_NONE;
      rpt.payload_start  = '0;
      rpt.payload_length = '0;
      bl    = eff_len(begin_len);
      el    = eff_len(end_len);
      found = 0;
      if (overflowed) begin
        rpt.status = mlfl_pkg::ST_OVERFLOW;
      end else begin
        for (b = 0; b < fill && !found; b++) begin
          if (tag_hit(b, begin_tag, bl)) begin
            for (e = b; e < fill && !found; e++) begin
              if (e >= b + bl + 1 && tag_hit(e, end_tag, el)) begin
                span = e - b - bl;
                if (int'(frame_mem[b+bl]) == span - 1) begin
                  found              = 1;
                  rpt.status         = mlfl_pkg::ST_FOUND;
                  rpt.payload_start  = mlfl_pkg::START_W'(b + bl + 1);
                  rpt.payload_length = mlfl_pkg::PLEN_W'(span - 1);
                end
              end
            end
          end
        end
      end
      return rpt;
    endfunction

    function void take_byte(input logic [mlfl_pkg::BYTE_W-1:0] data, input logic last);
      if (fill < DEPTH) begin
        frame_mem[fill] = data;
        fill++;
      end else begin
        overflowed = 1;
      end
      if (last) begin
        awaited_reports.push_back(search_frame());
        fill       = 0;
        overflowed = 0;
      end
    endfunction

    function void check_report(input mlfl_pkg::out_beat_t got);
      mlfl_pkg::out_beat_t want;
      if (awaited_reports.size() == 0) begin
        $error("result beat with nothing pending: status %0d start %0d length %0d",
               got.status, got.payload_start, got.payload_length);
        failures++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.payload_start !== want.payload_start) begin
        $error("payload_start: expected %0d, actual %0d",
               want.payload_start, got.payload_start);
        failures++;
      end
      if (got.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, actual %0d",
               want.payload_length, got.payload_length);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mlfl_in_if  in_ch ();
  mlfl_out_if out_ch ();
  mlfl_cfg_if cfg_ch ();

  marker_length_frame_locator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  locator_scoreboard sb;
  idle_mode_e        idle_mode;
  int unsigned       byte_beats;
  int unsigned       stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Idling knobs. Sender drops valid half the time in its phase, 21 percent of
  // the time when both sides idle; receiver likewise with ready.
  // ---------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 50;
      IDLE_BOTH:   return $urandom_range(0, 99) < 21;
      default:     return 0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 50;
      IDLE_BOTH:     return $urandom_range(0, 99) < 21;
      default:       return 0;
    endcase
  endfunction

  // mostly legal lengths, now and then the zero and saturating codes
  function automatic int unsigned pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; handshakes are seen on the
  // rising edge. valid stays high after a beat so back-to-back bytes stream;
  // idle gaps drop it, and rest_sender lowers it before a drain.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [mlfl_pkg::BYTE_W-1:0] data, input logic last);
    @(negedge clk_i);
    while (sender_gap()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.beat  <= '{data_byte: data, last_byte: last};
    do @(posedge clk_i); while (!in_ch.ready);
    sb.take_byte(data, last);
    byte_beats++;
  endtask

  task automatic send_frame(input logic [mlfl_pkg::BYTE_W-1:0] q [$]);
    int unsigned i;
    for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic rest_sender();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // pause the byte stream until every report is back, then let the block settle
  task automatic wait_drain();
    rest_sender();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mlfl_pkg::REG_IDX_W-1:0] idx,
                           input logic [mlfl_pkg::REG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.beat  <= '{reg_idx: idx, wr_data: data};
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Length registers only keep three bits; junk above them is written half the
  // time. One write to an unmapped index rides along and must change nothing.
  task automatic configure(input logic [mlfl_pkg::TAG_W-1:0] btag, input int unsigned blen,
                           input logic [mlfl_pkg::TAG_W-1:0] etag, input int unsigned elen);
    logic [mlfl_pkg::REG_DATA_W-1:0] upper;
    upper = $urandom_range(0, 1) ? ($urandom << mlfl_pkg::TAG_LEN_W) : '0;
    write_reg(mlfl_pkg::REG_BEGIN_TAG, btag);
    write_reg(mlfl_pkg::REG_BEGIN_TAG_LEN, upper | mlfl_pkg::TAG_LEN_W'(blen));
    write_reg(mlfl_pkg::REG_END_TAG, etag);
    write_reg(mlfl_pkg::REG_END_TAG_LEN, upper | mlfl_pkg::TAG_LEN_W'(elen));
    write_reg(mlfl_pkg::REG_IDX_W'($urandom_range(4, 255)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Frame builder. Most frames are well formed around random content: noise,
  // begin marker, length byte, payload, end marker, noise. Some carry a bad
  // length byte or lose the end marker; a few are plain noise.
  // ---------------------------------------------------------------------------
  task automatic build_frame(ref logic [mlfl_pkg::BYTE_W-1:0] q [$]);
    int unsigned                 kind;
    int unsigned                 bl;
    int unsigned                 el;
    int unsigned                 plen;
    int unsigned                 k;
    logic [mlfl_pkg::BYTE_W-1:0] len_byte;
    kind = $urandom_range(0, 99);
    bl   = sb.eff_len(sb.begin_len);
    el   = sb.eff_len(sb.end_len);
    q.delete();
    if (kind < 12) begin
      repeat ($urandom_range(1, 40)) q.push_back(mlfl_pkg::BYTE_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) q.push_back(mlfl_pkg::BYTE_W'($urandom_range(0, 255)));
      for (k = 0; k < bl; k++) q.push_back(sb.begin_tag[8*k +: 8]);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      len_byte = mlfl_pkg::BYTE_W'(plen);
      if (kind >= 82) begin
        len_byte = kind[0] ? mlfl_pkg::BYTE_W'(plen + 1)
                           : mlfl_pkg::BYTE_W'($urandom_range(0, 255));
      end
      q.push_back(len_byte);
      repeat (plen) q.push_back(mlfl_pkg::BYTE_W'($urandom_range(0, 255)));
      if (kind < 92) begin
        for (k = 0; k < el; k++) q.push_back(sb.end_tag[8*k +: 8]);
      end
      repeat ($urandom_range(0, 4)) q.push_back(mlfl_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Fill the buffer to the brim, the frame flush against its end; extra bytes
  // past that overflow it.
  task automatic send_full_buffer(input int unsigned extra);
    logic [mlfl_pkg::BYTE_W-1:0] q [$];
    logic [mlfl_pkg::BYTE_W-1:0] nb;
    int unsigned                 bl;
    int unsigned                 el;
    int unsigned                 k;
    bl = sb.eff_len(sb.begin_len);
    el = sb.eff_len(sb.end_len);
    // keep the filler free of the first begin byte so the scan stays short
    while (q.size() < DEPTH - bl - el - 1) begin
      nb = mlfl_pkg::BYTE_W'($urandom_range(0, 255));
      if (nb == sb.begin_tag[7:0]) nb ^= 8'h01;
      q.push_back(nb);
    end
    for (k = 0; k < bl; k++) q.push_back(sb.begin_tag[8*k +: 8]);
    q.push_back(8'h00);
    for (k = 0; k < el; k++) q.push_back(sb.end_tag[8*k +: 8]);
    repeat (extra) q.push_back(mlfl_pkg::BYTE_W'($urandom_range(0, 255)));
    send_frame(q);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready is redrawn every falling edge, reports are checked on
  // the rising edge they are accepted.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !receiver_stall();
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_report(out_ch.beat);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [mlfl_pkg::BYTE_W-1:0] q [$];
    int unsigned                 ph;
    int unsigned                 target;
    sb           = new();
    idle_mode    = IDLE_NONE;
    byte_beats   = 0;
    in_ch.valid  = 1'b0;
    in_ch.beat   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.beat  = '0;
    rst_ni       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset registers (zero markers, one byte each).
    // lone byte: begin and end hit the same spot, no room for a length byte
    q = '{8'h00};
    send_frame(q);
    // length byte would sit on the end marker itself: still nothing
    q = '{8'h00, 8'h00};
    send_frame(q);
    // shortest frame: empty payload
    q = '{8'h00, 8'h00, 8'h00};
    send_frame(q);
    wait_drain();

    // all-ones four-byte begin marker against an all-zero end marker
    configure(32'hFFFF_FFFF, 4, 32'h0000_0000, 1);
    q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hAB, 8'h00};
    send_frame(q);
    wait_drain();
    // zero-length begin marker never matches
    write_reg(mlfl_pkg::REG_BEGIN_TAG_LEN, 0);
    q = '{8'hFF, 8'hFF, 8'h00};
    send_frame(q);
    wait_drain();
    // oversize length code behaves as the four-byte maximum
    write_reg(mlfl_pkg::REG_BEGIN_TAG_LEN, 7);
    q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hAB, 8'h00};
    send_frame(q);
    wait_drain();

    // Random phases, each with its own registers and idling pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      case (ph)
        0:       configure('0, 1, '0, 1);
        1:       configure('1, 4, '1, 4);
        2:       configure($urandom, 0, $urandom, 7);
        3:       configure($urandom, 6, $urandom, 5);
        default: configure($urandom, pick_len(), $urandom, pick_len());
      endcase
      target = byte_beats + RANDOM_BYTES / PHASES;
      while (byte_beats < target) begin
        build_frame(q);
        send_frame(q);
        // occasionally hold the stream until the block has answered everything
        if ($urandom_range(0, 29) == 0) wait_drain();
      end
      wait_drain();
    end

    // Buffer edge: filled to the brim and then past it.
    idle_mode = IDLE_BOTH;
    configure($urandom, 1, $urandom, 1);
    send_full_buffer($urandom_range(1, 6));
    wait_drain();

    repeat (END_SETTLE) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mlfl_pkg.sv
rtl/mlfl_if.sv
rtl/mlfl_frame_buf.sv
rtl/marker_length_frame_locator.sv
tb/sv/testbench.sv
